@@ rtl/wswe_pkg.sv @@
// ----------------------------------------------------------------------------
// wswe_pkg: shared constants for the wheel speed window estimator
// Field widths, fixed-point scale constants and parameter defaults.
// ----------------------------------------------------------------------------
package wswe_pkg;

   localparam int COUNT_W   = 32;  // free-running pulse counter
   localparam int TIME_W    = 24;  // elapsed time, microseconds
   localparam int ROLLOUT_W = 24;  // feet per pulse, Q8.16
   localparam int SPEED_W   = 16;  // speed, 1/256 mph
   localparam int DIST_W    = 48;  // distance, Q32.16 feet

   // speed = floor(P * R * SPD_NUM / (SPD_DEN * T))
   localparam int                   SPD_NUM_W = 18;
   localparam logic [SPD_NUM_W-1:0] SPD_NUM   = 18'd234375;
   localparam int                   SPD_DEN_W = 7;
   localparam logic [SPD_DEN_W-1:0] SPD_DEN   = 7'd88;

   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

   localparam int DEF_WINDOW_DEPTH = 8;
   // pulse sum (32 + log2 depth) times rollout times SPD_NUM
   localparam int DEF_ALU_WIDTH    = COUNT_W + $clog2(DEF_WINDOW_DEPTH)
                                     + ROLLOUT_W + SPD_NUM_W;

endpackage

@@ rtl/wswe_alu.sv @@
// ----------------------------------------------------------------------------
// wswe_alu: shared add / subtract unit
// One wide adder used by the multiply, compare and divide steps of the estimator.
// ----------------------------------------------------------------------------
module wswe_alu #(
   parameter int WIDTH = wswe_pkg::DEF_ALU_WIDTH
) (
   input  logic [WIDTH-1:0] op_a,
   input  logic [WIDTH-1:0] op_b,
   input  logic             sub,
   output logic [WIDTH-1:0] result,
   output logic             a_ge_b
);

   logic [WIDTH:0] sum;

   // subtract as a + ~b + 1; carry out means no borrow
   assign sum    = {1'b0, op_a} + {1'b0, (sub ? ~op_b : op_b)} + {{WIDTH{1'b0}}, sub};
   assign result = sum[WIDTH-1:0];
   assign a_ge_b = sum[WIDTH];

endmodule

@@ rtl/wheel_speed_window_estimator_core.sv @@
// ----------------------------------------------------------------------------
// wheel_speed_window_estimator_core: moving-window wheel speed and distance
// Keeps a ring of recent pulse/time samples and reports window speed in
// 1/256 mph and accumulated distance in Q32.16 feet for each sample word.
// ----------------------------------------------------------------------------
// Usage:
//   csr_*  : write the rollout (Q8.16 feet per pulse) while the block is idle;
//            csr_ready is always high.
//   req_*  : one sample word: counter value, elapsed microseconds and a
//            distance-take flag. req_ready is high only while idle.
//   rsp_*  : one result word per sample: speed and distance. The distance
//            includes this sample; a take request clears it afterwards.
// Sequence: a sample runs READ, DIST, a bit-serial multiply over the PSUM_W
//   pulse-sum bits (PSUM_W = 32 + log2(WINDOW_DEPTH)), a compare, a restoring
//   divide for 16 quotient bits and a load in DONE, all on the shared wide
//   adder in wswe_alu. The compare skips the divide when the window time is
//   zero or speed saturates. A new sample is taken only after the last one
//   has been loaded in DONE.
// Reset (synchronous): rollout, counters, sums, distance and ring position
//   go to zero; ring contents are only used once the ring has wrapped.
// Stall: a finished word sits in the output register; a new sample may be
//   taken meanwhile, and its result waits in DONE until the slot frees.
// ----------------------------------------------------------------------------
module wheel_speed_window_estimator_core #(
   parameter int WINDOW_DEPTH = wswe_pkg::DEF_WINDOW_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [wswe_pkg::ROLLOUT_W-1:0]  csr_rollout,

   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [wswe_pkg::COUNT_W-1:0]    req_counter_value,
   input  logic [wswe_pkg::TIME_W-1:0]     req_elapsed_us,
   input  logic                            req_take_distance,

   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [wswe_pkg::SPEED_W-1:0]    rsp_speed,
   output logic [wswe_pkg::DIST_W-1:0]     rsp_distance
);

   import wswe_pkg::*;

   localparam int PTR_W  = $clog2(WINDOW_DEPTH);
   localparam int PSUM_W = COUNT_W + PTR_W;
   localparam int TSUM_W = TIME_W + PTR_W;
   localparam int RK_W   = ROLLOUT_W + SPD_NUM_W;
   localparam int N_W    = PSUM_W + RK_W;
   localparam int D_W    = TSUM_W + SPD_DEN_W;
   localparam int CNT_W  = $clog2(PSUM_W);
   localparam int MEM_W  = COUNT_W + TIME_W;
   localparam int PROD_W = COUNT_W + ROLLOUT_W;
   localparam int DSUM_W = PROD_W + 1;
   localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(WINDOW_DEPTH - 1);

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_READ = 7'b0000010,
      S_DIST = 7'b0000100,
      S_MUL  = 7'b0001000,
      S_CMP  = 7'b0010000,
      S_DIV  = 7'b0100000,
      S_DONE = 7'b1000000
   } state_type;

   state_type               state_ff, state_in;
   logic [ROLLOUT_W-1:0]    rollout_ff, rollout_in;
   logic [COUNT_W-1:0]      last_count_ff, last_count_in;
   logic [PTR_W-1:0]        pos_ff, pos_in;
   logic                    full_ff, full_in;
   logic [PSUM_W-1:0]       psum_ff, psum_in;
   logic [TSUM_W-1:0]       tsum_ff, tsum_in;
   logic [DIST_W-1:0]       dist_ff, dist_in;
   logic [COUNT_W-1:0]      delta_ff, delta_in;
   logic [TIME_W-1:0]       dt_ff, dt_in;
   logic                    take_ff, take_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic [RK_W-1:0]         rk_ff, rk_in;
   logic [D_W-1:0]          d_ff, d_in;
   logic [N_W-1:0]          acc_ff, acc_in;
   logic [PSUM_W-1:0]       pmul_ff, pmul_in;
   logic [SPEED_W-1:0]      nlo_ff, nlo_in;
   logic [D_W-1:0]          rem_ff, rem_in;
   logic [SPEED_W-1:0]      q_ff, q_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SPEED_W-1:0]      rsp_speed_ff, rsp_speed_in;
   logic [DIST_W-1:0]       rsp_distance_ff, rsp_distance_in;

   logic [MEM_W-1:0]        ring_mem [WINDOW_DEPTH];
   logic [MEM_W-1:0]        rd_ff;

   logic                    req_accept;
   logic [N_W-1:0]          alu_a, alu_b, alu_y;
   logic                    alu_sub, alu_ge;
   logic [COUNT_W-1:0]      old_p;
   logic [TIME_W-1:0]       old_t;
   logic [DSUM_W-1:0]       dsum;

   assign csr_ready    = 1'b1;
   assign req_ready    = (state_ff == S_IDLE);
   assign req_accept   = req_valid && req_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_speed    = rsp_speed_ff;
   assign rsp_distance = rsp_distance_ff;

   assign old_p = rd_ff[MEM_W-1:TIME_W];
   assign old_t = rd_ff[TIME_W-1:0];
   assign dsum  = DSUM_W'(dist_ff) + DSUM_W'(prod_ff);

   // Sample ring: read the slot being replaced on accept, write the new sample into it in READ.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_ff <= ring_mem[pos_ff];
      end
      if (state_ff == S_READ) begin
         ring_mem[pos_ff] <= {delta_ff, dt_ff};
      end
   end

   // Shared adder: multiply accumulate, saturation compare, divide step.
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      case (state_ff)
         S_MUL: begin
            alu_a = {acc_ff[N_W-2:0], 1'b0};
            alu_b = pmul_ff[PSUM_W-1] ? N_W'(rk_ff) : '0;
         end
         S_CMP: begin
            // quotient fits 16 bits only if N / 2^16 < d
            alu_a   = N_W'(acc_ff[N_W-1:SPEED_W]);
            alu_b   = N_W'(d_ff);
            alu_sub = 1'b1;
         end
         S_DIV: begin
            alu_a   = N_W'({rem_ff, nlo_ff[SPEED_W-1]});
            alu_b   = N_W'(d_ff);
            alu_sub = 1'b1;
         end
         default: begin
            alu_sub = 1'b0;
         end
      endcase
   end

   wswe_alu #(
      .WIDTH (N_W)
   ) u_alu (
      .op_a   (alu_a),
      .op_b   (alu_b),
      .sub    (alu_sub),
      .result (alu_y),
      .a_ge_b (alu_ge)
   );

   // Sequencer
   always_comb begin
      state_in        = state_ff;
      rollout_in      = csr_valid ? csr_rollout : rollout_ff;
      last_count_in   = last_count_ff;
      pos_in          = pos_ff;
      full_in         = full_ff;
      psum_in         = psum_ff;
      tsum_in         = tsum_ff;
      dist_in         = dist_ff;
      delta_in        = delta_ff;
      dt_in           = dt_ff;
      take_in         = take_ff;
      prod_in         = prod_ff;
      rk_in           = rk_ff;
      d_in            = d_ff;
      acc_in          = acc_ff;
      pmul_in         = pmul_ff;
      nlo_in          = nlo_ff;
      rem_in          = rem_ff;
      q_in            = q_ff;
      cnt_in          = cnt_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_speed_in    = rsp_speed_ff;
      rsp_distance_in = rsp_distance_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               delta_in      = req_counter_value - last_count_ff;
               last_count_in = req_counter_value;
               dt_in         = req_elapsed_us;
               take_in       = req_take_distance;
               state_in      = S_READ;
            end
         end
         S_READ: begin
            // drop the oldest sample once the ring has wrapped
            psum_in = psum_ff - (full_ff ? PSUM_W'(old_p) : '0) + PSUM_W'(delta_ff);
            tsum_in = tsum_ff - (full_ff ? TSUM_W'(old_t) : '0) + TSUM_W'(dt_ff);
            if (pos_ff == LAST_POS) begin
               pos_in  = '0;
               full_in = 1'b1;
            end else begin
               pos_in  = pos_ff + PTR_W'(1);
            end
            prod_in  = PROD_W'(delta_ff) * PROD_W'(rollout_ff);
            rk_in    = RK_W'(rollout_ff) * RK_W'(SPD_NUM);
            state_in = S_DIST;
         end
         S_DIST: begin
            dist_in  = (dsum[DSUM_W-1:DIST_W] != '0) ? DIST_MAX : dsum[DIST_W-1:0];
            d_in     = D_W'(tsum_ff) * D_W'(SPD_DEN);
            acc_in   = '0;
            pmul_in  = psum_ff;
            cnt_in   = CNT_W'(PSUM_W - 1);
            state_in = S_MUL;
         end
         S_MUL: begin
            // MSB-first shift-add of pulse sum times rollout*SPD_NUM
            acc_in  = alu_y;
            pmul_in = {pmul_ff[PSUM_W-2:0], 1'b0};
            cnt_in  = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            nlo_in = acc_ff[SPEED_W-1:0];
            rem_in = acc_ff[SPEED_W +: D_W];
            cnt_in = CNT_W'(SPEED_W - 1);
            q_in   = '0;
            if (tsum_ff == '0) begin
               state_in = S_DONE;
            end else if (alu_ge) begin
               q_in     = '1;
               state_in = S_DONE;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            rem_in = alu_ge ? alu_y[D_W-1:0] : alu_a[D_W-1:0];
            q_in   = {q_ff[SPEED_W-2:0], alu_ge};
            nlo_in = {nlo_ff[SPEED_W-2:0], 1'b0};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_speed_in    = q_ff;
               rsp_distance_in = dist_ff;
               if (take_ff) begin
                  dist_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rollout_ff    <= '0;
         last_count_ff <= '0;
         pos_ff        <= '0;
         full_ff       <= 1'b0;
         psum_ff       <= '0;
         tsum_ff       <= '0;
         dist_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rollout_ff    <= rollout_in;
         last_count_ff <= last_count_in;
         pos_ff        <= pos_in;
         full_ff       <= full_in;
         psum_ff       <= psum_in;
         tsum_ff       <= tsum_in;
         dist_ff       <= dist_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      delta_ff        <= delta_in;
      dt_ff           <= dt_in;
      take_ff         <= take_in;
      prod_ff         <= prod_in;
      rk_ff           <= rk_in;
      d_ff            <= d_in;
      acc_ff          <= acc_in;
      pmul_ff         <= pmul_in;
      nlo_ff          <= nlo_in;
      rem_ff          <= rem_in;
      q_ff            <= q_in;
      cnt_ff          <= cnt_in;
      rsp_speed_ff    <= rsp_speed_in;
      rsp_distance_ff <= rsp_distance_in;
   end

`ifndef SYNTHESIS
   // once the ring has wrapped it stays full until reset
   a_full_sticky: assert property (@(posedge clock) disable iff (reset)
      full_ff |=> full_ff)
      else $error("ring full flag dropped");

   // restoring divide keeps the partial remainder below the divisor
   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (rem_ff < d_ff))
      else $error("divide remainder out of range");

   // zero window time gives zero speed and skips the divide
   a_zero_time: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP && tsum_ff == '0) |=> (q_ff == '0 && state_ff == S_DONE))
      else $error("zero window time not reported as zero speed");
`endif

endmodule

@@ verif/tb_wheel_speed_window_estimator_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wheel_speed_window_estimator_core: self-checking bench for the estimator
// Drives sample words with random gaps and back-pressure, predicts window
// speed and odometer distance for each accepted word in a scoreboard class,
// and compares every result word field by field across several rollouts.
// ----------------------------------------------------------------------------
module tb_wheel_speed_window_estimator_core;
   import wswe_pkg::*;

   localparam int DEPTH         = DEF_WINDOW_DEPTH;
   localparam int PSUM_W        = COUNT_W + $clog2(DEPTH);
   localparam int TSUM_W        = TIME_W + $clog2(DEPTH);
   // settle time after the end of the run, longer than the slowest sample
   localparam int SETTLE_CYCLES = PSUM_W + 40;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int IDLE_PCT      = 30;

   typedef struct packed {
      logic [SPEED_W-1:0] speed;
      logic [DIST_W-1:0]  distance;
   } result_word_type;

   // Scoreboard: its own copy of the sample ring, window sums and odometer,
   // plus the queue of result words still owed by the block.
   class window_speed_model_type;
      logic [ROLLOUT_W-1:0] rollout;
      logic [COUNT_W-1:0]   prev_count;
      logic [COUNT_W-1:0]   pulse_hist [DEPTH];
      logic [TIME_W-1:0]    time_hist [DEPTH];
      int                   slot;
      bit                   wrapped;
      logic [PSUM_W-1:0]    pulse_total;
      logic [TSUM_W-1:0]    time_total;
      logic [DIST_W-1:0]    odometer;
      result_word_type      expected_words [$];
      int                   mismatches;

      function new();
         rollout     = '0;
         prev_count  = '0;
         slot        = 0;
         wrapped     = 0;
         pulse_total = '0;
         time_total  = '0;
         odometer    = '0;
         mismatches  = 0;
      endfunction

      function void set_rollout(logic [ROLLOUT_W-1:0] value);
         rollout = value;
      endfunction

      // floor(P * R * SPD_NUM / (SPD_DEN * T)), saturated; zero with no time
      function logic [SPEED_W-1:0] window_speed();
         logic [95:0] num;
         logic [95:0] den;
         if (time_total == '0)
            return '0;
         num = pulse_total;
         num = num * rollout;
         num = num * SPD_NUM;
         den = time_total;
         den = den * SPD_DEN;
         if (num >= (den << SPEED_W))
            return {SPEED_W{1'b1}};
         return SPEED_W'(num / den);
      endfunction

      function void note_sample(logic [COUNT_W-1:0] count, logic [TIME_W-1:0] usec,
                                logic take);
         logic [COUNT_W-1:0] delta;
         logic [63:0]        step_dist;
         logic [63:0]        sum;
         result_word_type    w;
         delta      = count - prev_count;
         prev_count = count;
         // retire the oldest entry once the ring has wrapped
         if (wrapped) begin
            pulse_total -= pulse_hist[slot];
            time_total  -= time_hist[slot];
         end
         pulse_hist[slot] = delta;
         time_hist[slot]  = usec;
         pulse_total     += delta;
         time_total      += usec;
         if (slot == DEPTH - 1) begin
            slot    = 0;
            wrapped = 1;
         end else begin
            slot++;
         end
         step_dist = delta;
         step_dist = step_dist * rollout;
         sum       = step_dist + odometer;
         odometer  = (sum > DIST_MAX) ? DIST_MAX : sum[DIST_W-1:0];
         w.speed    = window_speed();
         w.distance = odometer;
         expected_words.insert(expected_words.size(), w);
         if (take)
            odometer = '0;
      endfunction

      function void check_word(logic [SPEED_W-1:0] speed, logic [DIST_W-1:0] distance);
         result_word_type w;
         if (expected_words.size() == 0) begin
            $error("unexpected result word: speed %0d distance 0x%0h", speed, distance);
            mismatches++;
            return;
         end
         w = expected_words[0];
         expected_words.delete(0);
         if (speed !== w.speed) begin
            $error("speed: expected %0d, actual %0d", w.speed, speed);
            mismatches++;
         end
         if (distance !== w.distance) begin
            $error("distance: expected 0x%0h, actual 0x%0h", w.distance, distance);
            mismatches++;
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [ROLLOUT_W-1:0] csr_rollout;
   logic                 req_valid;
   logic                 req_ready;
   logic [COUNT_W-1:0]   req_counter_value;
   logic [TIME_W-1:0]    req_elapsed_us;
   logic                 req_take_distance;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [SPEED_W-1:0]   rsp_speed;
   logic [DIST_W-1:0]    rsp_distance;

   window_speed_model_type speed_model;
   logic [COUNT_W-1:0]   wheel_count;   // last counter value sent
   bit                   steady;        // set: neither side idles
   bit                   req_held;      // req_valid is being held high
   int unsigned          cycle_count = 0;

   wheel_speed_window_estimator_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_rollout       (csr_rollout),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_counter_value (req_counter_value),
      .req_elapsed_us    (req_elapsed_us),
      .req_take_distance (req_take_distance),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_speed         (rsp_speed),
      .rsp_distance      (rsp_distance)
   );

   always #10 clock = ~clock;

   // Hard stop: a hung handshake must never keep the run alive.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Result side: check the word that was accepted at this edge, then pick
   // the next ready level. Outputs are read before any update of this edge.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            speed_model.check_word(rsp_speed, rsp_distance);
         rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Drop valid only if it is held; never lower and raise it in one step.
   task automatic drop_valid();
      if (req_held) begin
         req_valid <= 1'b0;
         req_held   = 0;
      end
   endtask

   // Offer one sample word, with a random gap first, and hold it until taken.
   task automatic send_sample(input logic [COUNT_W-1:0] count,
                              input logic [TIME_W-1:0] usec, input logic take);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         drop_valid();
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_counter_value <= count;
      req_elapsed_us    <= usec;
      req_take_distance <= take;
      req_held           = 1;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      speed_model.note_sample(count, usec, take);
      wheel_count = count;
   endtask

   // Hold off the sender until every owed result word has come back.
   task automatic drain_results();
      drop_valid();
      @(posedge clock);
      while (speed_model.expected_words.size() != 0)
         @(posedge clock);
   endtask

   // Write the rollout; only called while the block is idle.
   task automatic write_rollout(input logic [ROLLOUT_W-1:0] value);
      csr_valid   <= 1'b1;
      csr_rollout <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      speed_model.set_rollout(value);
      csr_valid <= 1'b0;
   endtask

   task automatic directed_samples();
      int i;
      // rollout still at its reset value of zero
      send_sample('0, '0, 1'b0);                   // first sample, zero window time
      send_sample('1, '1, 1'b1);                   // all-ones fields, take distance
      drain_results();
      write_rollout(24'h07_3000);
      // steady pulses; the first step wraps the counter past zero
      for (i = 0; i < 10; i++)
         send_sample(wheel_count + 32'd5, 24'd100000, i == 6);
      // flush the whole window with zero time
      for (i = 0; i < DEPTH; i++)
         send_sample(wheel_count, '0, 1'b0);
      // many pulses over one microsecond: speed saturates
      send_sample(wheel_count + 32'd1000, 24'd1, 1'b0);
      drain_results();
      write_rollout('1);
      // all-ones delta at full rollout: distance saturates, then gets taken
      send_sample(wheel_count - 32'd1, 24'd1000, 1'b0);
      send_sample(wheel_count, 24'd1000, 1'b1);
      send_sample(wheel_count + 32'd3, 24'd1000, 1'b0);
   endtask

   // Mostly a wheel turning at road speed; the rest is noise and odd timing.
   task automatic random_sample();
      int                 pick;
      logic [COUNT_W-1:0] count;
      logic [TIME_W-1:0]  usec;
      logic               take;
      pick  = $urandom_range(99);
      count = wheel_count + $urandom_range(60);
      usec  = TIME_W'($urandom_range(200000, 20000));
      take  = ($urandom_range(15) == 0);
      if (pick >= 96) begin
         count = $urandom();
         usec  = TIME_W'($urandom_range(24'hFF_FFFF));
         take  = 1'($urandom_range(1));
      end else if (pick >= 90) begin
         count = wheel_count + $urandom();        // counter jump
      end else if (pick >= 85) begin
         usec = TIME_W'($urandom_range(8, 1));    // tiny interval, fast window
      end else if (pick >= 80) begin
         usec = '0;
      end
      send_sample(count, usec, take);
   endtask

   task automatic run_phase(input logic [ROLLOUT_W-1:0] value, input int samples,
                            input bit quiet);
      drain_results();
      write_rollout(value);
      steady = quiet;
      repeat (samples) begin
         // now and then, let the pipeline run dry before the next word
         if ($urandom_range(99) == 0)
            drain_results();
         random_sample();
      end
      steady = 0;
   endtask

   initial begin
      speed_model = new();
      steady      = 0;
      req_held    = 0;
      wheel_count = '0;
      reset             <= 1'b1;
      csr_valid         <= 1'b0;
      csr_rollout       <= '0;
      req_valid         <= 1'b0;
      req_counter_value <= '0;
      req_elapsed_us    <= '0;
      req_take_distance <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed_samples();
      run_phase('0, 150, 0);
      run_phase('1, 150, 0);
      run_phase(ROLLOUT_W'($urandom_range(24'h10_0000, 24'h02_0000)), 150, 1);
      run_phase(ROLLOUT_W'($urandom_range(24'hFF_FFFF)), 150, 0);
      run_phase(ROLLOUT_W'($urandom_range(255, 1)), 150, 0);
      run_phase(ROLLOUT_W'($urandom_range(24'h10_0000, 24'h02_0000)), 150, 0);
      run_phase(ROLLOUT_W'($urandom_range(24'hFF_FFFF)), 150, 0);

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (speed_model.mismatches == 0 && speed_model.expected_words.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/wswe_pkg.sv
rtl/wswe_alu.sv
rtl/wheel_speed_window_estimator_core.sv
verif/tb_wheel_speed_window_estimator_core.sv
